### design/swrd_pkg.sv
`default_nettype none
package swrd_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int ADDR_W        = 32;
  localparam int TIME_W        = 32;
  localparam int LIMIT_W       = 6;
  localparam int COUNT_W       = 7;
  localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
  localparam int GRP_SIZE      = 8;
  localparam int GRP_N         = (TABLE_ENTRIES + GRP_SIZE - 1) / GRP_SIZE;
  localparam int GRP_W         = $clog2(GRP_SIZE + 1);

  localparam int IN_DATA_W     = 64;
  localparam int OUT_DATA_W    = 48;
  localparam int CFG_ADDR_W    = 3;
  localparam int CFG_DATA_W    = 32;

  localparam logic [LIMIT_W-1:0] LIMIT_RST  = 6'd10;
  localparam logic [TIME_W-1:0]  WINDOW_RST = 32'd60;

  // register word index, taken from paddr[2]
  localparam logic REG_LIMIT  = 1'b0;
  localparam logic REG_WINDOW = 1'b1;

  typedef struct packed {
    logic insert;  // shift new entry in at the head
    logic check;   // evaluate keep/match, update valid bits
    logic prune;   // apply the age test during check
  } tbl_ctl_t;

endpackage
`default_nettype wire

### design/swrd_cell.sv
`default_nettype none
module swrd_cell (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire swrd_pkg::tbl_ctl_t           ctl,
  input  wire logic [swrd_pkg::ADDR_W-1:0]  key_addr,
  input  wire logic [swrd_pkg::TIME_W-1:0]  key_time,
  input  wire logic [swrd_pkg::TIME_W-1:0]  window,
  input  wire logic [swrd_pkg::ADDR_W-1:0]  prev_addr,
  input  wire logic [swrd_pkg::TIME_W-1:0]  prev_time,
  input  wire logic                         full_in,
  output logic                              full_out,
  output logic [swrd_pkg::ADDR_W-1:0]       addr_out,
  output logic [swrd_pkg::TIME_W-1:0]       time_out,
  output logic                              keep,
  output logic                              match
);

  logic                        valid_r;
  logic                        valid_nxt;
  logic [swrd_pkg::ADDR_W-1:0] addr_r;
  logic [swrd_pkg::TIME_W-1:0] time_r;
  logic [swrd_pkg::TIME_W-1:0] age;
  logic                        take;

  // all cells below are occupied: this cell absorbs the shift
  assign take     = ctl.insert & full_in;
  assign full_out = full_in & valid_r;
  assign addr_out = addr_r;
  assign time_out = time_r;

  assign age   = key_time - time_r;
  assign keep  = valid_r & (~ctl.prune | (age < window));
  assign match = keep & (addr_r == key_addr);

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (ctl.check) begin
      valid_nxt = keep;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      addr_r <= prev_addr;
      time_r <= prev_time;
    end
  end

endmodule
`default_nettype wire

### design/swrd_table.sv
`default_nettype none
module swrd_table (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire swrd_pkg::tbl_ctl_t           ctl,
  input  wire logic [swrd_pkg::ADDR_W-1:0]  new_addr,
  input  wire logic [swrd_pkg::TIME_W-1:0]  new_time,
  input  wire logic [swrd_pkg::ADDR_W-1:0]  key_addr,
  input  wire logic [swrd_pkg::TIME_W-1:0]  key_time,
  input  wire logic [swrd_pkg::TIME_W-1:0]  window,
  output logic                              full,
  output logic [swrd_pkg::CNT_W-1:0]        occ_sum,
  output logic [swrd_pkg::CNT_W-1:0]        match_sum
);

  localparam int N    = swrd_pkg::TABLE_ENTRIES;
  localparam int PADN = swrd_pkg::GRP_N * swrd_pkg::GRP_SIZE;

  logic [swrd_pkg::ADDR_W-1:0] addr_chain [N+1];
  logic [swrd_pkg::TIME_W-1:0] time_chain [N+1];
  logic [N:0]                  full_chain;
  logic [N-1:0]                keep_v;
  logic [N-1:0]                match_v;
  logic [PADN-1:0]             keep_pad;
  logic [PADN-1:0]             match_pad;

  logic [swrd_pkg::GRP_W-1:0] keep_grp_r  [swrd_pkg::GRP_N];
  logic [swrd_pkg::GRP_W-1:0] match_grp_r [swrd_pkg::GRP_N];
  logic [swrd_pkg::GRP_W-1:0] keep_grp_nxt  [swrd_pkg::GRP_N];
  logic [swrd_pkg::GRP_W-1:0] match_grp_nxt [swrd_pkg::GRP_N];

  assign addr_chain[0] = new_addr;
  assign time_chain[0] = new_time;
  assign full_chain[0] = 1'b1;
  assign full          = full_chain[N];

  for (genvar i = 0; i < N; i++) begin : g_cell
    swrd_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .key_addr  (key_addr),
      .key_time  (key_time),
      .window    (window),
      .prev_addr (addr_chain[i]),
      .prev_time (time_chain[i]),
      .full_in   (full_chain[i]),
      .full_out  (full_chain[i+1]),
      .addr_out  (addr_chain[i+1]),
      .time_out  (time_chain[i+1]),
      .keep      (keep_v[i]),
      .match     (match_v[i])
    );
  end

  assign keep_pad  = PADN'(keep_v);
  assign match_pad = PADN'(match_v);

  // first level of the count tree: one popcount per group of cells
  always_comb begin
    for (int g = 0; g < swrd_pkg::GRP_N; g++) begin
      keep_grp_nxt[g]  = '0;
      match_grp_nxt[g] = '0;
      for (int j = 0; j < swrd_pkg::GRP_SIZE; j++) begin
        keep_grp_nxt[g]  = keep_grp_nxt[g] +
                           swrd_pkg::GRP_W'(keep_pad[g*swrd_pkg::GRP_SIZE + j]);
        match_grp_nxt[g] = match_grp_nxt[g] +
                           swrd_pkg::GRP_W'(match_pad[g*swrd_pkg::GRP_SIZE + j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.check) begin
      keep_grp_r  <= keep_grp_nxt;
      match_grp_r <= match_grp_nxt;
    end
  end

  always_comb begin
    occ_sum   = '0;
    match_sum = '0;
    for (int g = 0; g < swrd_pkg::GRP_N; g++) begin
      occ_sum   = occ_sum + swrd_pkg::CNT_W'(keep_grp_r[g]);
      match_sum = match_sum + swrd_pkg::CNT_W'(match_grp_r[g]);
    end
  end

endmodule
`default_nettype wire

### design/sliding_window_source_rate_detector.sv
// Each item passes three steps in turn (insert shift, age/match check across the
// cell chain, group count sum) and is accepted only while no item is in flight;
// a stalled output holds the sum step.
// Reset clears every cell valid bit, the occupancy and the output valid, and
// loads request_limit = 10, window_seconds = 60; entry contents are not cleared.
`default_nettype none
module sliding_window_source_rate_detector (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  // [31:0] source_address, [63:32] event_time
  input  wire logic [swrd_pkg::IN_DATA_W-1:0]       in_tdata,
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  // [31:0] reported_address, [38:32] window_count, [39] limit_reached,
  // [40] table_overflow, [47:41] zero
  output logic [swrd_pkg::OUT_DATA_W-1:0]           out_tdata,
  input  wire logic                                 cfg_psel,
  input  wire logic                                 cfg_penable,
  input  wire logic                                 cfg_pwrite,
  input  wire logic [swrd_pkg::CFG_ADDR_W-1:0]      cfg_paddr,
  input  wire logic [swrd_pkg::CFG_DATA_W-1:0]      cfg_pwdata,
  output logic [swrd_pkg::CFG_DATA_W-1:0]           cfg_prdata,
  output logic                                      cfg_pready
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SUM
  } state_t;

  state_t                        state_r;
  logic [swrd_pkg::LIMIT_W-1:0]  limit_r;
  logic [swrd_pkg::TIME_W-1:0]   window_r;
  logic [swrd_pkg::CNT_W-1:0]    occ_r;
  logic [swrd_pkg::ADDR_W-1:0]   key_addr_r;
  logic [swrd_pkg::TIME_W-1:0]   key_time_r;
  logic                          ovf_r;
  logic                          out_tvalid_r;
  logic [swrd_pkg::ADDR_W-1:0]   out_addr_r;
  logic [swrd_pkg::COUNT_W-1:0]  out_cnt_r;
  logic                          out_lim_r;
  logic                          out_ovf_r;

  logic                          in_xact;
  logic                          cfg_wr;
  logic                          out_load;
  logic                          tbl_full;
  logic [swrd_pkg::CNT_W-1:0]    occ_sum;
  logic [swrd_pkg::CNT_W-1:0]    match_sum;
  logic [31:0]                   match_ext;
  swrd_pkg::tbl_ctl_t            ctl;

  assign in_tready = (state_r == ST_IDLE);
  assign in_xact   = in_tvalid & in_tready;
  assign cfg_pready = 1'b1;
  assign cfg_wr    = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == swrd_pkg::REG_WINDOW) ? window_r :
                      swrd_pkg::CFG_DATA_W'(limit_r);
  assign out_load  = (state_r == ST_SUM) && (!out_tvalid_r || out_tready);

  assign ctl.insert = in_xact;
  assign ctl.check  = (state_r == ST_CHECK);
  assign ctl.prune  = (32'(occ_r) > 32'(limit_r));

  assign match_ext  = 32'(match_sum);

  swrd_table u_table (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .new_addr  (in_tdata[31:0]),
    .new_time  (in_tdata[63:32]),
    .key_addr  (key_addr_r),
    .key_time  (key_time_r),
    .window    (window_r),
    .full      (tbl_full),
    .occ_sum   (occ_sum),
    .match_sum (match_sum)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r  <= swrd_pkg::LIMIT_RST;
      window_r <= swrd_pkg::WINDOW_RST;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == swrd_pkg::REG_LIMIT) begin
        limit_r <= cfg_pwdata[swrd_pkg::LIMIT_W-1:0];
      end else begin
        window_r <= cfg_pwdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      occ_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_xact) begin
            if (!tbl_full) begin
              occ_r <= occ_r + 1'b1;
            end
            state_r <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          state_r <= ST_SUM;
        end
        ST_SUM: begin
          if (out_load) begin
            occ_r   <= occ_sum;
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_xact) begin
      key_addr_r <= in_tdata[31:0];
      key_time_r <= in_tdata[63:32];
      ovf_r      <= tbl_full;
    end
    if (out_load) begin
      out_addr_r <= key_addr_r;
      out_cnt_r  <= match_ext[swrd_pkg::COUNT_W-1:0];
      out_lim_r  <= (match_ext >= 32'(limit_r));
      out_ovf_r  <= ovf_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {7'b0, out_ovf_r, out_lim_r, out_cnt_r, out_addr_r};

`ifndef SYNTHESIS
  a_accept_to_check: assert property (@(posedge clk) disable iff (!rst_n)
    in_xact |=> (state_r == ST_CHECK))
    else $error("accepted transaction did not start the check step");

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= swrd_pkg::CNT_W'(swrd_pkg::TABLE_ENTRIES))
    else $error("occupancy beyond table size");

  a_full_holds_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xact && tbl_full) |=> (occ_r == swrd_pkg::CNT_W'(swrd_pkg::TABLE_ENTRIES)))
    else $error("full table insert changed occupancy");
`endif

endmodule
`default_nettype wire

### verif/sliding_window_source_rate_detector_test.sv
`default_nettype none
module sliding_window_source_rate_detector_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [swrd_pkg::ADDR_W-1:0] addr;
    logic [swrd_pkg::TIME_W-1:0] stamp;
  } request_t;

  typedef struct {
    logic [swrd_pkg::ADDR_W-1:0]  addr;
    logic [swrd_pkg::COUNT_W-1:0] count;
    logic                         hit;
    logic                         ovf;
  } report_t;

  class rate_scoreboard;
    request_t                     window_q[$];
    report_t                      reports[$];
    logic [swrd_pkg::LIMIT_W-1:0] limit  = swrd_pkg::LIMIT_RST;
    logic [swrd_pkg::TIME_W-1:0]  window = swrd_pkg::WINDOW_RST;
    int                           errors = 0;

    function void write_reg(logic sel, logic [swrd_pkg::CFG_DATA_W-1:0] value);
      if (sel == swrd_pkg::REG_LIMIT) begin
        limit = value[swrd_pkg::LIMIT_W-1:0];
      end else begin
        window = value[swrd_pkg::TIME_W-1:0];
      end
    endfunction

    function void note_request(logic [swrd_pkg::IN_DATA_W-1:0] data);
      request_t req;
      request_t kept[$];
      report_t  rep;
      int       n;
      req.addr  = data[31:0];
      req.stamp = data[63:32];
      rep.ovf = (window_q.size() == swrd_pkg::TABLE_ENTRIES);
      if (rep.ovf) begin
        void'(window_q.pop_front());
      end
      window_q = {window_q, req};
      if (window_q.size() > limit) begin
        foreach (window_q[i]) begin
          if (swrd_pkg::TIME_W'(req.stamp - window_q[i].stamp) < window) begin
            kept = {kept, window_q[i]};
          end
        end
        window_q = kept;
      end
      n = 0;
      foreach (window_q[i]) begin
        if (window_q[i].addr == req.addr) begin
          n++;
        end
      end
      rep.addr  = req.addr;
      rep.count = n[swrd_pkg::COUNT_W-1:0];
      rep.hit   = (n >= int'(limit));
      reports = {reports, rep};
    endfunction

    function void check_report(logic [swrd_pkg::OUT_DATA_W-1:0] data);
      report_t rep;
      if (reports.size() == 0) begin
        $display("%0t unexpected result transaction, actual %h", $time, data);
        errors++;
        return;
      end
      rep = reports.pop_front();
      if (data[31:0] !== rep.addr) begin
        $display("%0t reported_address expected %h actual %h", $time, rep.addr, data[31:0]);
        errors++;
      end
      if (data[38:32] !== rep.count) begin
        $display("%0t window_count expected %0d actual %0d", $time, rep.count, data[38:32]);
        errors++;
      end
      if (data[39] !== rep.hit) begin
        $display("%0t limit_reached expected %b actual %b", $time, rep.hit, data[39]);
        errors++;
      end
      if (data[40] !== rep.ovf) begin
        $display("%0t table_overflow expected %b actual %b", $time, rep.ovf, data[40]);
        errors++;
      end
      if (data[47:41] !== 7'd0) begin
        $display("%0t pad bits expected 0 actual %h", $time, data[47:41]);
        errors++;
      end
    endfunction
  endclass

  logic                            clk;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [swrd_pkg::IN_DATA_W-1:0]  in_tdata;
  logic                            out_tvalid;
  logic                            out_tready;
  logic [swrd_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                            cfg_psel;
  logic                            cfg_penable;
  logic                            cfg_pwrite;
  logic [swrd_pkg::CFG_ADDR_W-1:0] cfg_paddr;
  logic [swrd_pkg::CFG_DATA_W-1:0] cfg_pwdata;
  logic [swrd_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic                            cfg_pready;

  bit gaps_on   = 1'b1;
  bit stalls_on = 1'b1;

  rate_scoreboard sb = new();

  sliding_window_source_rate_detector dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      sb.note_request(in_tdata);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_report(out_tdata);
    end
  end

  // result side backpressure
  initial begin
    int stall;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = stalls_on ? $urandom_range(0, 15) : 0;
      if (stall > 0) begin
        out_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready = 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
      @(negedge clk);
    end
  end

  // called at a falling edge; returns at the falling edge after the transaction
  task automatic send_request(logic [swrd_pkg::ADDR_W-1:0] addr,
                              logic [swrd_pkg::TIME_W-1:0] stamp);
    int gap;
    gap = gaps_on ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  = {stamp, addr};
    in_tvalid = 1'b1;
    do @(posedge clk); while (in_tready !== 1'b1);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_tvalid = 1'b0;
    while (sb.reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_register(logic sel, logic [swrd_pkg::CFG_DATA_W-1:0] value);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = {sel, 2'b00};
    cfg_pwdata  = value;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    sb.write_reg(sel, value);
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
  endtask

  task automatic set_config(logic [swrd_pkg::LIMIT_W-1:0] lim,
                            logic [swrd_pkg::TIME_W-1:0] win);
    logic [swrd_pkg::CFG_DATA_W-1:0] v;
    drain_results();
    v = $urandom;
    v[swrd_pkg::LIMIT_W-1:0] = lim;
    write_register(swrd_pkg::REG_LIMIT, v);
    write_register(swrd_pkg::REG_WINDOW, win);
  endtask

  initial begin
    logic [swrd_pkg::ADDR_W-1:0]  pool [8];
    int                           pool_n;
    logic [swrd_pkg::ADDR_W-1:0]  addr;
    logic [swrd_pkg::TIME_W-1:0]  now;
    logic [swrd_pkg::LIMIT_W-1:0] lim;
    logic [swrd_pkg::TIME_W-1:0]  win;
    int                           r;

    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset settings: limit 10, window 60
    send_request(32'h0000_0000, 32'h0000_0000);
    send_request(32'hFFFF_FFFF, 32'h0000_0000);
    for (int i = 1; i <= 10; i++) begin
      send_request(32'hC0A8_0001, i);
    end
    send_request(32'hC0A8_0001, 32'd100);

    // zero limit: every append prunes, always flagged
    set_config(6'd0, 32'd5);
    send_request(32'h0A00_0001, 32'd1000);
    send_request(32'h0A00_0001, 32'd1003);
    send_request(32'h0A00_0001, 32'd1010);

    // zero window: prune empties the table
    set_config(6'd2, 32'd0);
    send_request(32'h0A00_0002, 32'd5);
    send_request(32'h0A00_0002, 32'd5);
    send_request(32'h0A00_0002, 32'd6);

    // time going backward and wrapping
    set_config(6'd1, 32'd10);
    send_request(32'h0A00_0003, 32'd200);
    send_request(32'h0A00_0003, 32'd100);
    send_request(32'h0A00_0003, 32'hFFFF_FFFF);
    send_request(32'h0A00_0003, 32'd5);

    for (int ph = 0; ph < 12; ph++) begin
      case (ph)
        0: begin
          lim = 6'd63;
          win = 32'hFFFF_FFFF;
        end
        1: begin
          lim = 6'd1;
          win = 32'd1;
        end
        2: begin
          lim = 6'd63;
          win = 32'd1;
        end
        3: begin
          lim = 6'd1;
          win = 32'hFFFF_FFFF;
        end
        default: begin
          lim = ($urandom_range(0, 9) == 0) ? 6'd0 : 6'($urandom_range(1, 63));
          r = $urandom_range(0, 9);
          if (r == 0) begin
            win = 32'd0;
          end else if (r == 1) begin
            win = 32'hFFFF_FFFF;
          end else if (r == 2) begin
            win = $urandom;
          end else if (r < 6) begin
            win = $urandom_range(1, 20);
          end else begin
            win = $urandom_range(20, 400);
          end
        end
      endcase
      set_config(lim, win);
      pool_n = $urandom_range(1, 8);
      foreach (pool[i]) begin
        pool[i] = $urandom;
      end
      now = $urandom;
      for (int k = 0; k < 125; k++) begin
        if (k % 25 == 0) begin
          gaps_on   = ($urandom_range(0, 3) != 0);
          stalls_on = ($urandom_range(0, 3) != 0);
        end
        r = $urandom_range(0, 99);
        if (r < 70) begin
          now = now + $urandom_range(0, 3);
        end else if (r < 90) begin
          now = now + $urandom_range(0, 50);
        end else if (r < 98) begin
          now = now + $urandom_range(0, 5000);
        end else begin
          now = $urandom;
        end
        addr = ($urandom_range(0, 99) < 85) ?
               pool[3'($urandom_range(0, pool_n - 1))] : $urandom;
        send_request(addr, now);
      end
    end

    in_tvalid = 1'b0;
    while (sb.reports.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire
